// ----- src/gsa_pkg.sv -----
// Package for the generational slot allocator: command, status and
// slot-state codes, widths, and the controller/datapath interface structs.
`timescale 1ns / 1ps
package gsa_pkg;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RETIRE  = 3'd1,
        CMD_COLLECT = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_AVAIL   = 3'd4,
        CMD_COUNT   = 3'd5
    } t_cmd;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_FOREIGN    = 3'd2;
    localparam logic [2:0] ST_STALE      = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC  = 3'd4;
    localparam logic [2:0] ST_RETIRED    = 3'd5;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd6;

    localparam logic [1:0] SS_FREE    = 2'd0;
    localparam logic [1:0] SS_ACTIVE  = 2'd1;
    localparam logic [1:0] SS_RETIRED = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch request, begin command
        logic walk_step; // process one retirement list entry
        logic walk_done; // commit list length after walk
        logic emit;      // load the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_end;  // no list entries left to visit
        logic hit;       // current entry is due (value <= completed) during collect
        logic hit_any;   // at least one entry freed so far
    } t_dp_stat;
endpackage

// ----- src/generational_slot_allocator.sv -----
// Generational slot allocator: accepts one request at a time. Allocate, retire, query,
// availability and unused codes are accepted, then their result is loaded; collect and
// collectable count walk the retirement list one entry per cycle, pausing while a freed
// handle waits for the output, then load the result. Every result load, including each
// freed handle of a collect after the first, also waits while the output holds an
// untaken result. Depends on gsa_pkg, gsa_ctrl and gsa_datapath.
`timescale 1ns / 1ps
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_slot_index,
    input  logic [31:0] i_slot_generation,
    input  logic [15:0] i_handle_owner,
    input  logic [63:0] i_completion_value,
    input  logic [6:0]  i_request_count,
    input  logic [7:0]  i_extra_reclaimable,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_has_slot,
    output logic [5:0]  o_out_index,
    output logic [31:0] o_out_generation,
    output logic        o_is_active,
    output logic [7:0]  o_count,
    output logic        o_last
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_walk, w_busy;

    gsa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_walk_cmd(w_walk), .i_out_busy(w_busy), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    gsa_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_cmd, .i_slot_index, .i_slot_generation, .i_handle_owner,
        .i_completion_value, .i_request_count, .i_extra_reclaimable,
        .i_dcmd(w_cmd), .o_stat(w_stat), .o_walk_cmd(w_walk), .o_out_busy(w_busy),
        .i_out_ready(i_ready), .o_out_valid(o_valid),
        .o_status, .o_has_slot, .o_out_index, .o_out_generation,
        .o_is_active, .o_count, .o_last
    );
endmodule

// ----- src/gsa_ctrl.sv -----
// Controller state machine for the slot allocator.
// Depends on gsa_pkg; drives gsa_datapath through t_dp_cmd.
`timescale 1ns / 1ps
module gsa_ctrl
    import gsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_walk_cmd,   // collect or count: needs the list walk
    input  logic     i_out_busy,   // output register holds an untaken result
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_walk_cmd ? S_WALK : S_FIN;
                end
            end
            S_WALK: begin
                if (i_stat.walk_end) begin
                    o_cmd.walk_done = 1'b1;
                    n_state = S_FIN;
                end else if (!i_stat.hit) begin
                    o_cmd.walk_step = 1'b1;
                end else if (!i_stat.hit_any || !i_out_busy) begin
                    // a due entry during collect releases the handle freed before it
                    o_cmd.walk_step = 1'b1;
                    o_cmd.emit      = i_stat.hit_any;
                end
            end
            S_FIN: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_out_busy) else $error("emit over busy output");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> r_state == S_IDLE) else $error("start outside idle");
endmodule

// ----- src/gsa_datapath.sv -----
// Datapath: slot table, free stack, retirement list and output register.
// Depends on gsa_pkg; sequenced by gsa_ctrl.
`timescale 1ns / 1ps
module gsa_datapath
    import gsa_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_slot_index,
    input  logic [31:0] i_slot_generation,
    input  logic [15:0] i_handle_owner,
    input  logic [63:0] i_completion_value,
    input  logic [6:0]  i_request_count,
    input  logic [7:0]  i_extra_reclaimable,
    input  t_dp_cmd     i_dcmd,
    output t_dp_stat    o_stat,
    output logic        o_walk_cmd,
    output logic        o_out_busy,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic        o_has_slot,
    output logic [5:0]  o_out_index,
    output logic [31:0] o_out_generation,
    output logic        o_is_active,
    output logic [7:0]  o_count,
    output logic        o_last
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [15:0]   r_owner_id;
    logic [1:0]    r_sstat [CAPACITY];
    logic [31:0]   r_sgen_d [CAPACITY];   // generation - 1, so reset is zero
    logic [IW-1:0] r_stack [CAPACITY];    // stored XOR (CAPACITY-1-i)
    logic [CW-1:0] r_free_cnt;
    logic [IW-1:0] r_rslot [CAPACITY];
    logic [63:0]   r_rval [CAPACITY];
    logic [CW-1:0] r_rcnt;

    // latched request
    logic [2:0]    r_cmd;
    logic [7:0]    r_idx;
    logic [31:0]   r_gen;
    logic [15:0]   r_own;
    logic [63:0]   r_val;
    logic [6:0]    r_req;
    logic [7:0]    r_extra;
    // walk
    logic [CW-1:0] r_rd, r_wr;
    logic [7:0]    r_hits;
    // freed handle held until the next one or the end of the walk
    logic          r_pend;
    logic [IW-1:0] r_pidx;
    logic [31:0]   r_pgen;

    logic          r_ovalid;
    logic [2:0]    r_ostatus;
    logic          r_ohas;
    logic [5:0]    r_oidx;
    logic [31:0]   r_ogen;
    logic          r_oact;
    logic [7:0]    r_ocnt;
    logic          r_olast;

    logic [2:0]    n_ostatus;
    logic          n_ohas;
    logic [5:0]    n_oidx;
    logic [31:0]   n_ogen;
    logic          n_oact;
    logic [7:0]    n_ocnt;
    logic          n_olast;

    function automatic logic [IW-1:0] stack_rst(input int i);
        return IW'(CAPACITY - 1 - i);
    endfunction

    // handle check on latched request
    logic [2:0]    chk;
    logic [IW-1:0] hidx;
    logic [31:0]   hgen_cur;
    assign hidx     = r_idx[IW-1:0];
    assign hgen_cur = r_sgen_d[hidx] + 32'd1;
    always_comb begin
        if (r_gen == '0 || r_own == '0)        chk = ST_INVALID;
        else if (r_own != r_owner_id)           chk = ST_FOREIGN;
        else if ({24'd0, r_idx} >= 32'(CAPACITY)) chk = ST_INVALID;
        else if (r_gen != hgen_cur)             chk = ST_STALE;
        else                                    chk = ST_OK;
    end

    logic [1:0] hstat;
    assign hstat = r_sstat[hidx];
    logic [2:0] ret_st;
    always_comb begin
        ret_st = chk;
        if (chk == ST_OK) begin
            if (hstat == SS_FREE)         ret_st = ST_NOT_ALLOC;
            else if (hstat == SS_RETIRED) ret_st = ST_RETIRED;
        end
    end

    // walk entry
    logic [IW-1:0] rd_i, ws;
    logic          due;
    assign rd_i = r_rd[IW-1:0];
    assign ws   = r_rslot[rd_i];
    assign due  = r_rval[rd_i] <= r_val;
    assign o_walk_cmd = (i_cmd == CMD_COLLECT) || (i_cmd == CMD_COUNT);
    assign o_stat.walk_end = (r_rd >= r_rcnt);
    assign o_stat.hit      = due && (r_cmd == CMD_COLLECT);
    assign o_stat.hit_any  = r_pend;

    logic [8:0]  safe;
    assign safe = 9'(r_free_cnt) + 9'(r_extra);
    logic [IW-1:0] pop_a, pop_i;
    assign pop_a = r_free_cnt[IW-1:0] - IW'(1);
    assign pop_i = r_stack[pop_a] ^ stack_rst(int'(pop_a));

    always_comb begin
        n_ostatus = ST_OK;
        n_ohas    = 1'b0;
        n_oidx    = '0;
        n_ogen    = '0;
        n_oact    = 1'b0;
        n_ocnt    = '0;
        n_olast   = 1'b1;
        if (i_dcmd.walk_step) begin
            // another due entry follows, so the held handle is not the last
            n_ohas  = 1'b1;
            n_oidx  = 6'(r_pidx);
            n_ogen  = r_pgen;
            n_olast = 1'b0;
        end else begin
            case (r_cmd)
                CMD_ALLOC: begin
                    if (r_free_cnt == '0) n_ostatus = ST_EXHAUSTED;
                    else begin
                        n_ohas = 1'b1;
                        n_oidx = 6'(pop_i);
                        n_ogen = r_sgen_d[pop_i] + 32'd1;
                    end
                end
                CMD_RETIRE: n_ostatus = ret_st;
                CMD_COLLECT: begin
                    n_ohas = r_pend;
                    n_oidx = r_pend ? 6'(r_pidx) : 6'd0;
                    n_ogen = r_pend ? r_pgen : 32'd0;
                end
                CMD_QUERY: n_oact = (chk == ST_OK) && (hstat == SS_ACTIVE);
                CMD_AVAIL: begin
                    n_ostatus = (9'(r_req) <= safe) ? ST_OK : ST_EXHAUSTED;
                    n_ocnt    = (safe > 9'd255) ? 8'd255 : safe[7:0];
                end
                CMD_COUNT: n_ocnt = r_hits;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_id <= 16'd1;
            r_free_cnt <= CW'(CAPACITY);
            r_rcnt     <= '0;
            r_pend     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_ostatus  <= ST_OK;
            r_ohas     <= 1'b0;
            r_oidx     <= '0;
            r_ogen     <= '0;
            r_oact     <= 1'b0;
            r_ocnt     <= '0;
            r_olast    <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_sstat[i]  <= SS_FREE;
                r_sgen_d[i] <= '0;
                r_stack[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) r_owner_id <= i_cfg_data;
            r_ovalid <= i_dcmd.emit || (r_ovalid && !i_out_ready);

            if (i_dcmd.start) begin
                r_cmd <= i_cmd; r_idx <= i_slot_index; r_gen <= i_slot_generation;
                r_own <= i_handle_owner; r_val <= i_completion_value;
                r_req <= i_request_count; r_extra <= i_extra_reclaimable;
                r_rd <= '0; r_wr <= '0; r_hits <= '0; r_pend <= 1'b0;
            end

            if (i_dcmd.walk_step) begin
                r_rd <= r_rd + CW'(1);
                if (r_cmd == CMD_COLLECT) begin
                    if (!due) begin
                        r_rslot[r_wr[IW-1:0]] <= ws;
                        r_rval[r_wr[IW-1:0]]  <= r_rval[rd_i];
                        r_wr <= r_wr + CW'(1);
                    end else begin
                        r_pend <= 1'b1;
                        r_pidx <= ws;
                        r_pgen <= r_sgen_d[ws] + 32'd1;
                        r_sgen_d[ws] <= (r_sgen_d[ws] == 32'hFFFF_FFFE) ? 32'd0
                                                                       : r_sgen_d[ws] + 32'd1;
                        r_sstat[ws] <= SS_FREE;
                        if (r_free_cnt < CW'(CAPACITY)) begin
                            r_stack[r_free_cnt[IW-1:0]] <= ws ^ stack_rst(int'(r_free_cnt));
                            r_free_cnt <= r_free_cnt + CW'(1);
                        end
                    end
                end else if (due) begin
                    r_hits <= r_hits + 8'd1;
                end
            end
            if (i_dcmd.walk_done && r_cmd == CMD_COLLECT) r_rcnt <= r_wr;

            if (i_dcmd.emit) begin
                r_ostatus <= n_ostatus;
                r_ohas    <= n_ohas;
                r_oidx    <= n_oidx;
                r_ogen    <= n_ogen;
                r_oact    <= n_oact;
                r_ocnt    <= n_ocnt;
                r_olast   <= n_olast;
            end

            if (i_dcmd.emit && !i_dcmd.walk_step) begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (r_free_cnt != '0) begin
                            r_sstat[pop_i] <= SS_ACTIVE;
                            r_free_cnt <= r_free_cnt - CW'(1);
                        end
                    end
                    CMD_RETIRE: begin
                        if (ret_st == ST_OK && r_rcnt < CW'(CAPACITY)) begin
                            r_sstat[hidx] <= SS_RETIRED;
                            r_rslot[r_rcnt[IW-1:0]] <= hidx;
                            r_rval[r_rcnt[IW-1:0]]  <= r_val;
                            r_rcnt <= r_rcnt + CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_out_busy       = r_ovalid;
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_has_slot       = r_ohas;
    assign o_out_index      = r_oidx;
    assign o_out_generation = r_ogen;
    assign o_is_active      = r_oact;
    assign o_count          = r_ocnt;
    assign o_last           = r_olast;
endmodule
